>>> sv/hysteresis_alarm_reporter_defines.svh
// Assertion macros shared by the hysteresis alarm reporter RTL
`ifndef HYSTERESIS_ALARM_REPORTER_DEFINES_SVH
`define HYSTERESIS_ALARM_REPORTER_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define HAR_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset
`define HAR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/har_pkg.sv
// Shared types and constants of the hysteresis alarm reporter
`default_nettype none

package har_pkg;

    // Parameter defaults
    localparam int DEF_SAMPLE_WIDTH = 16;
    localparam int DEF_NORMAL_SKIP  = 3;
    localparam int DEF_WARNING_SKIP = 2;

    // Tick counter is wide enough for skip values up to 15
    localparam int CNT_W = 4;

    // Configuration register file
    localparam int LIMIT_W    = 16;
    localparam int BAND_W     = 15;
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 5;
    localparam int REG_IDX_W  = 3;

    localparam logic [REG_IDX_W-1:0] REG_TEMP_HIGH = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_CO2_LOW   = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_CO2_HIGH  = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_PM_LOW    = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_PM_HIGH   = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_TEMP_BAND = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_CO2_BAND  = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_PM_BAND   = 3'd7;

    // Register reset values
    localparam logic signed [LIMIT_W-1:0] RST_TEMP_HIGH = 16'sd2500;
    localparam logic signed [LIMIT_W-1:0] RST_CO2_LOW   = 16'sd280;
    localparam logic signed [LIMIT_W-1:0] RST_CO2_HIGH  = 16'sd300;
    localparam logic signed [LIMIT_W-1:0] RST_PM_LOW    = 16'sd200;
    localparam logic signed [LIMIT_W-1:0] RST_PM_HIGH   = 16'sd300;
    localparam logic [BAND_W-1:0]         RST_TEMP_BAND = 15'd500;
    localparam logic [BAND_W-1:0]         RST_CO2_BAND  = 15'd10;
    localparam logic [BAND_W-1:0]         RST_PM_BAND   = 15'd50;

    // Limit flag vector layout
    localparam int NUM_FLAGS   = 5;
    localparam int F_TEMP_OVER = 0;
    localparam int F_CO2_UNDER = 1;
    localparam int F_CO2_OVER  = 2;
    localparam int F_PM_UNDER  = 3;
    localparam int F_PM_OVER   = 4;

    // Why a sample is reported
    typedef enum logic [2:0] {
        R_NONE     = 3'd0,
        R_FIRST    = 3'd1,
        R_ENTERED  = 3'd2,
        R_CLEARED  = 3'd3,
        R_WARN_PER = 3'd4,
        R_NORM_PER = 3'd5
    } t_reason;

endpackage

`default_nettype wire

>>> sv/har_ifs.sv
// Sample and report channel interfaces of the hysteresis alarm reporter
`default_nettype none

interface har_sample_if
    import har_pkg::*;
#(
    parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH
);
    logic                           valid;
    logic                           ready;
    logic                           enabled;
    logic signed [SAMPLE_WIDTH-1:0] temp_sample;
    logic signed [SAMPLE_WIDTH-1:0] co2_sample;
    logic signed [SAMPLE_WIDTH-1:0] pm_sample;

    modport source (output valid, enabled, temp_sample, co2_sample, pm_sample,
                    input ready);
    modport sink   (input valid, enabled, temp_sample, co2_sample, pm_sample,
                    output ready);
endinterface

interface har_report_if
    import har_pkg::*;
#(
    parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH
);
    logic                           valid;
    logic                           ready;
    logic                           publish;
    t_reason                        report_reason;
    logic                           warning_active;
    logic                           temp_over;
    logic                           co2_under;
    logic                           co2_over;
    logic                           pm_under;
    logic                           pm_over;
    logic signed [SAMPLE_WIDTH-1:0] temp_report;
    logic signed [SAMPLE_WIDTH-1:0] co2_report;
    logic signed [SAMPLE_WIDTH-1:0] pm_report;

    modport source (output valid, publish, report_reason, warning_active, temp_over,
                    co2_under, co2_over, pm_under, pm_over, temp_report, co2_report,
                    pm_report, input ready);
    modport sink   (input valid, publish, report_reason, warning_active, temp_over,
                    co2_under, co2_over, pm_under, pm_over, temp_report, co2_report,
                    pm_report, output ready);
endinterface

`default_nettype wire

>>> sv/hysteresis_alarm_reporter.sv
// Hysteresis alarm reporter: limit flags, warning mode and report scheduling
//
// Usage:
//   i_sample carries one sample triple per request (enabled, temperature, CO2,
//   particulate, signed hundredths). A request with enabled low is taken and
//   dropped: it yields no report and changes no state.
//   o_report carries one report per enabled request: publish, reason, warning
//   mode, the five limit flags after the step and the echoed samples. publish
//   low means the sample is not to be sent.
//   The APB port writes and reads the eight limit and band registers at byte
//   address 4*index; pready is tied high. Write only while the block is idle.
// Timing:
//   A request is registered at acceptance, evaluated from the input register
//   and lands in the report register. One request per cycle is sustained while
//   o_report.ready stays high; the only loop is the flag/mode/counter update.
// Reset (synchronous, active low): registers return to their defaults, normal
//   mode, flags clear, tick counter zero, first report pending.
// Stall: while o_report is held, the input register keeps one more request;
//   i_sample.ready drops only when both are full. Disabled requests drain.
`default_nettype none
`include "hysteresis_alarm_reporter_defines.svh"

module hysteresis_alarm_reporter
    import har_pkg::*;
#(
    parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH,
    parameter int NORMAL_SKIP  = DEF_NORMAL_SKIP,
    parameter int WARNING_SKIP = DEF_WARNING_SKIP
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    har_sample_if.sink                 i_sample,
    har_report_if.source               o_report,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready
);

    // Compare width: holds a sample, and a limit shifted by a band
    localparam int CW = ((SAMPLE_WIDTH > LIMIT_W + 1) ? SAMPLE_WIDTH : LIMIT_W + 1) + 1;
    localparam logic [CNT_W-1:0] N_SKIP = CNT_W'(NORMAL_SKIP);
    localparam logic [CNT_W-1:0] W_SKIP = CNT_W'(WARNING_SKIP);
    localparam logic [CNT_W-1:0] MAX_SKIP = (N_SKIP > W_SKIP) ? N_SKIP : W_SKIP;

    // Configuration registers
    logic signed [LIMIT_W-1:0] r_temp_high, r_co2_low, r_co2_high, r_pm_low, r_pm_high;
    logic        [BAND_W-1:0]  r_temp_band, r_co2_band, r_pm_band;

    // Input stage
    logic                           r_in_valid;
    logic                           r_in_en;
    logic signed [SAMPLE_WIDTH-1:0] r_in_temp, r_in_co2, r_in_pm;

    // Block state
    logic                 r_in_warning, n_in_warning;
    logic                 r_first_pending, n_first_pending;
    logic [CNT_W-1:0]     r_tick, n_tick;
    logic [NUM_FLAGS-1:0] r_flags, n_flags;
    t_reason              n_reason;

    // Result stage
    logic                           r_out_valid;
    t_reason                        r_out_reason;
    logic                           r_out_warning;
    logic [NUM_FLAGS-1:0]           r_out_flags;
    logic signed [SAMPLE_WIDTH-1:0] r_out_temp, r_out_co2, r_out_pm;

    logic w_cfg_wr;
    logic w_in_take;
    logic w_s1_move;
    logic w_s1_emit;

    logic signed [CW-1:0] w_t, w_c, w_p;
    logic signed [CW-1:0] w_th, w_cl, w_ch, w_pl, w_ph;
    logic signed [CW-1:0] w_th_clr, w_cl_clr, w_ch_clr, w_pl_clr, w_ph_clr;

    // Handshake: stage 1 moves when it is empty of work or the result slot frees
    assign w_s1_move = r_in_valid && (!r_in_en || !r_out_valid || o_report.ready);
    assign w_s1_emit = w_s1_move && r_in_en;
    assign i_sample.ready = !r_in_valid || w_s1_move;
    assign w_in_take = i_sample.valid && i_sample.ready;

    // APB register access
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_temp_high <= RST_TEMP_HIGH;
            r_co2_low   <= RST_CO2_LOW;
            r_co2_high  <= RST_CO2_HIGH;
            r_pm_low    <= RST_PM_LOW;
            r_pm_high   <= RST_PM_HIGH;
            r_temp_band <= RST_TEMP_BAND;
            r_co2_band  <= RST_CO2_BAND;
            r_pm_band   <= RST_PM_BAND;
        end else if (w_cfg_wr) begin
            case (paddr[APB_ADDR_W-1:2])
                REG_TEMP_HIGH: r_temp_high <= pwdata[LIMIT_W-1:0];
                REG_CO2_LOW:   r_co2_low   <= pwdata[LIMIT_W-1:0];
                REG_CO2_HIGH:  r_co2_high  <= pwdata[LIMIT_W-1:0];
                REG_PM_LOW:    r_pm_low    <= pwdata[LIMIT_W-1:0];
                REG_PM_HIGH:   r_pm_high   <= pwdata[LIMIT_W-1:0];
                REG_TEMP_BAND: r_temp_band <= pwdata[BAND_W-1:0];
                REG_CO2_BAND:  r_co2_band  <= pwdata[BAND_W-1:0];
                REG_PM_BAND:   r_pm_band   <= pwdata[BAND_W-1:0];
                default: ;
            endcase
        end
    end

    // Read back: limits sign-extended, bands zero-extended
    always_comb begin
        case (paddr[APB_ADDR_W-1:2])
            REG_TEMP_HIGH: prdata = APB_DATA_W'(r_temp_high);
            REG_CO2_LOW:   prdata = APB_DATA_W'(r_co2_low);
            REG_CO2_HIGH:  prdata = APB_DATA_W'(r_co2_high);
            REG_PM_LOW:    prdata = APB_DATA_W'(r_pm_low);
            REG_PM_HIGH:   prdata = APB_DATA_W'(r_pm_high);
            REG_TEMP_BAND: prdata = APB_DATA_W'(r_temp_band);
            REG_CO2_BAND:  prdata = APB_DATA_W'(r_co2_band);
            REG_PM_BAND:   prdata = APB_DATA_W'(r_pm_band);
            default:       prdata = '0;
        endcase
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_take) begin
            r_in_valid <= 1'b1;
        end else if (w_s1_move) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_in_en   <= i_sample.enabled;
            r_in_temp <= i_sample.temp_sample;
            r_in_co2  <= i_sample.co2_sample;
            r_in_pm   <= i_sample.pm_sample;
        end
    end

    // Widen samples, limits and clear thresholds to a common signed width
    assign w_t  = CW'(r_in_temp);
    assign w_c  = CW'(r_in_co2);
    assign w_p  = CW'(r_in_pm);
    assign w_th = CW'(r_temp_high);
    assign w_cl = CW'(r_co2_low);
    assign w_ch = CW'(r_co2_high);
    assign w_pl = CW'(r_pm_low);
    assign w_ph = CW'(r_pm_high);
    assign w_th_clr = w_th - CW'(signed'({1'b0, r_temp_band}));
    assign w_cl_clr = w_cl + CW'(signed'({1'b0, r_co2_band}));
    assign w_ch_clr = w_ch - CW'(signed'({1'b0, r_co2_band}));
    assign w_pl_clr = w_pl + CW'(signed'({1'b0, r_pm_band}));
    assign w_ph_clr = w_ph - CW'(signed'({1'b0, r_pm_band}));

    // Step: update flags, mode, counter and pick the report reason
    always_comb begin
        n_flags         = r_flags;
        n_in_warning    = r_in_warning;
        n_first_pending = r_first_pending;
        n_tick          = r_tick;
        n_reason        = R_NONE;
        if (!r_in_warning) begin
            n_flags[F_TEMP_OVER] = (w_t > w_th);
            if (w_c < w_cl) begin
                n_flags[F_CO2_UNDER] = 1'b1;
            end else if (w_c > w_ch) begin
                n_flags[F_CO2_OVER] = 1'b1;
            end else begin
                n_flags[F_CO2_UNDER] = 1'b0;
                n_flags[F_CO2_OVER]  = 1'b0;
            end
            if (w_p < w_pl) begin
                n_flags[F_PM_UNDER] = 1'b1;
            end else if (w_p > w_ph) begin
                n_flags[F_PM_OVER] = 1'b1;
            end else begin
                n_flags[F_PM_UNDER] = 1'b0;
                n_flags[F_PM_OVER]  = 1'b0;
            end
            if (n_flags != '0) begin
                n_reason     = R_ENTERED;
                n_in_warning = 1'b1;
                n_tick       = '0;
            end else if (r_first_pending) begin
                n_reason        = R_FIRST;
                n_first_pending = 1'b0;
            end else if (r_tick == N_SKIP) begin
                n_reason = R_NORM_PER;
                n_tick   = '0;
            end else begin
                n_tick = r_tick + 1'b1;
            end
        end else begin
            // Clear each set flag once its reading is a band back inside
            if (w_t <= w_th_clr) n_flags[F_TEMP_OVER] = 1'b0;
            if (w_c >= w_cl_clr) n_flags[F_CO2_UNDER] = 1'b0;
            if (w_c <= w_ch_clr) n_flags[F_CO2_OVER]  = 1'b0;
            if (w_p >= w_pl_clr) n_flags[F_PM_UNDER]  = 1'b0;
            if (w_p <= w_ph_clr) n_flags[F_PM_OVER]   = 1'b0;
            if (n_flags == '0) begin
                n_reason     = R_CLEARED;
                n_in_warning = 1'b0;
                n_tick       = '0;
            end else if (r_tick == W_SKIP) begin
                n_reason = R_WARN_PER;
                n_tick   = '0;
            end else begin
                n_tick = r_tick + 1'b1;
            end
        end
    end

    // State and result-valid registers; advance only on an enabled request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_warning    <= 1'b0;
            r_first_pending <= 1'b1;
            r_tick          <= '0;
            r_flags         <= '0;
            r_out_valid     <= 1'b0;
        end else begin
            if (w_s1_emit) begin
                r_in_warning    <= n_in_warning;
                r_first_pending <= n_first_pending;
                r_tick          <= n_tick;
                r_flags         <= n_flags;
                r_out_valid     <= 1'b1;
            end else if (o_report.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (w_s1_emit) begin
            r_out_reason  <= n_reason;
            r_out_warning <= n_in_warning;
            r_out_flags   <= n_flags;
            r_out_temp    <= r_in_temp;
            r_out_co2     <= r_in_co2;
            r_out_pm      <= r_in_pm;
        end
    end

    assign o_report.valid          = r_out_valid;
    assign o_report.publish        = (r_out_reason != R_NONE);
    assign o_report.report_reason  = r_out_reason;
    assign o_report.warning_active = r_out_warning;
    assign o_report.temp_over      = r_out_flags[F_TEMP_OVER];
    assign o_report.co2_under      = r_out_flags[F_CO2_UNDER];
    assign o_report.co2_over       = r_out_flags[F_CO2_OVER];
    assign o_report.pm_under       = r_out_flags[F_PM_UNDER];
    assign o_report.pm_over        = r_out_flags[F_PM_OVER];
    assign o_report.temp_report    = r_out_temp;
    assign o_report.co2_report     = r_out_co2;
    assign o_report.pm_report      = r_out_pm;

    // Warning mode always has a flag behind it
    `HAR_ASSERT_NOW(a_warn_has_flag, r_in_warning, r_flags != '0, "warning without flag")
    // Tick counter stays within the larger skip
    `HAR_ASSERT_NOW(a_tick_bound, 1'b1, r_tick <= MAX_SKIP, "tick counter out of range")
    // First report drops the pending mark together with its result
    `HAR_ASSERT_NOW(a_first_report, $fell(r_first_pending),
                    r_out_valid && r_out_reason == R_FIRST, "first report lost")
    // A cleared report returns to normal mode
    `HAR_ASSERT_NOW(a_cleared_normal, r_out_valid && r_out_reason == R_CLEARED,
                    !r_out_warning && r_out_flags == '0, "cleared report in warning")
    // Disabled request never produces a result
    `HAR_ASSERT_NEXT(a_disabled_drop, w_s1_move && !r_in_en && !r_out_valid,
                     !r_out_valid, "result from disabled request")

endmodule

`default_nettype wire

>>> test/testbench.sv
// Self-checking testbench for the hysteresis alarm reporter
module testbench
    import har_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SW          = DEF_SAMPLE_WIDTH;
    localparam int NSKIP       = DEF_NORMAL_SKIP;
    localparam int WSKIP       = DEF_WARNING_SKIP;
    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 60;
    localparam int DRAIN_TAIL  = 6;
    localparam int NUM_REGS    = 8;
    localparam int S_MIN       = -32768;
    localparam int S_MAX       = 32767;

    typedef struct {
        logic                  publish;
        t_reason               reason;
        logic                  warning;
        logic [NUM_FLAGS-1:0]  flags;
        logic signed [SW-1:0]  t;
        logic signed [SW-1:0]  c;
        logic signed [SW-1:0]  p;
    } t_report;

    typedef enum {STALL_NONE, STALL_LIGHT, STALL_PERIODIC, STALL_HEAVY} t_stall_mode;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    har_sample_if #(.SAMPLE_WIDTH(SW)) smp_if ();
    har_report_if #(.SAMPLE_WIDTH(SW)) rpt_if ();

    hysteresis_alarm_reporter dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_sample (smp_if),
        .o_report (rpt_if),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // Predicted block state and register copy
    logic                  warn_mode;
    logic                  first_due;
    logic [CNT_W-1:0]      tick;
    logic [NUM_FLAGS-1:0]  flag_state;
    logic [LIMIT_W-1:0]    reg_shadow [NUM_REGS];

    t_report               expected_reports [$];
    int                    error_count;
    int                    cycle_count;

    // Sender burst control and receiver hold request
    int                    burst_left;
    logic                  sender_idling;
    logic                  hold_request;
    int                    calm_left;
    logic                  calm_run;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Cycle limit
    initial cycle_count = 0;
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic void check_field(string name, logic signed [31:0] want,
                                        logic signed [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            error_count++;
        end
    endfunction

    function automatic int lim(logic [REG_IDX_W-1:0] idx);
        return int'($signed(reg_shadow[idx]));
    endfunction

    function automatic int band(logic [REG_IDX_W-1:0] idx);
        return int'(reg_shadow[idx][BAND_W-1:0]);
    endfunction

    // Normal-mode range update: a low reading keeps the over flag, a high one the under flag
    function automatic void update_range(int x, int lo, int hi, int under_bit, int over_bit);
        if (x < lo)
            flag_state[under_bit] = 1'b1;
        else if (x > hi)
            flag_state[over_bit] = 1'b1;
        else begin
            flag_state[under_bit] = 1'b0;
            flag_state[over_bit]  = 1'b0;
        end
    endfunction

    // Advance the predicted state by one enabled sample and queue its report
    function automatic void predict_report(logic signed [SW-1:0] ts, logic signed [SW-1:0] cs,
                                           logic signed [SW-1:0] ps);
        int      t;
        int      c;
        int      p;
        t_reason why;
        t_report r;
        t   = ts;
        c   = cs;
        p   = ps;
        why = R_NONE;
        if (!warn_mode) begin
            flag_state[F_TEMP_OVER] = (t > lim(REG_TEMP_HIGH));
            update_range(c, lim(REG_CO2_LOW), lim(REG_CO2_HIGH), F_CO2_UNDER, F_CO2_OVER);
            update_range(p, lim(REG_PM_LOW), lim(REG_PM_HIGH), F_PM_UNDER, F_PM_OVER);
            if (flag_state != '0) begin
                why       = R_ENTERED;
                warn_mode = 1'b1;
                tick      = '0;
            end else if (first_due) begin
                why       = R_FIRST;
                first_due = 1'b0;
            end else if (tick == NSKIP) begin
                why  = R_NORM_PER;
                tick = '0;
            end else begin
                tick = tick + 1'b1;
            end
        end else begin
            // Clear each flag only once its reading is a band inside the limit
            if (flag_state[F_TEMP_OVER] && t <= lim(REG_TEMP_HIGH) - band(REG_TEMP_BAND))
                flag_state[F_TEMP_OVER] = 1'b0;
            if (flag_state[F_CO2_UNDER] && c >= lim(REG_CO2_LOW) + band(REG_CO2_BAND))
                flag_state[F_CO2_UNDER] = 1'b0;
            if (flag_state[F_CO2_OVER] && c <= lim(REG_CO2_HIGH) - band(REG_CO2_BAND))
                flag_state[F_CO2_OVER] = 1'b0;
            if (flag_state[F_PM_UNDER] && p >= lim(REG_PM_LOW) + band(REG_PM_BAND))
                flag_state[F_PM_UNDER] = 1'b0;
            if (flag_state[F_PM_OVER] && p <= lim(REG_PM_HIGH) - band(REG_PM_BAND))
                flag_state[F_PM_OVER] = 1'b0;
            if (flag_state == '0) begin
                why       = R_CLEARED;
                warn_mode = 1'b0;
                tick      = '0;
            end else if (tick == WSKIP) begin
                why  = R_WARN_PER;
                tick = '0;
            end else begin
                tick = tick + 1'b1;
            end
        end
        r.publish = (why != R_NONE);
        r.reason  = why;
        r.warning = warn_mode;
        r.flags   = flag_state;
        r.t       = ts;
        r.c       = cs;
        r.p       = ps;
        expected_reports.push_back(r);
    endfunction

    // Compare each accepted report with the oldest prediction
    always @(posedge i_clk) begin : report_check
        t_report want;
        if (i_rst_n && rpt_if.valid === 1'b1 && rpt_if.ready === 1'b1) begin
            if (expected_reports.size() == 0) begin
                $error("report with no sample pending");
                error_count++;
            end else begin
                want = expected_reports.pop_front();
                check_field("publish", want.publish, rpt_if.publish);
                check_field("report_reason", want.reason, rpt_if.report_reason);
                check_field("warning_active", want.warning, rpt_if.warning_active);
                check_field("temp_over", want.flags[F_TEMP_OVER], rpt_if.temp_over);
                check_field("co2_under", want.flags[F_CO2_UNDER], rpt_if.co2_under);
                check_field("co2_over", want.flags[F_CO2_OVER], rpt_if.co2_over);
                check_field("pm_under", want.flags[F_PM_UNDER], rpt_if.pm_under);
                check_field("pm_over", want.flags[F_PM_OVER], rpt_if.pm_over);
                check_field("temp_report", want.t, rpt_if.temp_report);
                check_field("co2_report", want.c, rpt_if.co2_report);
                check_field("pm_report", want.p, rpt_if.pm_report);
            end
        end
    end

    // Receiver: change stall pattern now and then, hold off on request
    initial begin : report_receiver
        t_stall_mode mode;
        int          mode_left;
        int          hold_left;
        int          phase;
        rpt_if.ready = 1'b0;
        mode_left    = 0;
        hold_left    = 0;
        phase        = 0;
        mode         = STALL_NONE;
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                rpt_if.ready = 1'b0;
                hold_left--;
            end else begin
                if (mode_left == 0) begin
                    mode      = t_stall_mode'($urandom_range(3, 0));
                    mode_left = $urandom_range(200, 20);
                end
                mode_left--;
                phase++;
                case (mode)
                    STALL_NONE:     rpt_if.ready = 1'b1;
                    STALL_LIGHT:    rpt_if.ready = ($urandom_range(99, 0) >= 30);
                    STALL_PERIODIC: rpt_if.ready = (phase % 4 != 3);
                    default:        rpt_if.ready = ($urandom_range(99, 0) >= 75);
                endcase
            end
        end
    end

    // Offer one sample, with a random gap at the end of each burst
    task automatic send_sample(logic en, logic signed [SW-1:0] t, logic signed [SW-1:0] c,
                               logic signed [SW-1:0] p);
        @(negedge i_clk);
        if (sender_idling && burst_left == 0) begin
            smp_if.valid       = 1'b0;
            smp_if.enabled     = $urandom_range(1, 0);
            smp_if.temp_sample = $urandom;
            smp_if.co2_sample  = $urandom;
            smp_if.pm_sample   = $urandom;
            repeat ($urandom_range(6, 1)) @(negedge i_clk);
            burst_left = $urandom_range(24, 1);
        end
        if (burst_left > 0)
            burst_left--;
        smp_if.valid       = 1'b1;
        smp_if.enabled     = en;
        smp_if.temp_sample = t;
        smp_if.co2_sample  = c;
        smp_if.pm_sample   = p;
        do @(posedge i_clk); while (smp_if.ready !== 1'b1);
        if (en)
            predict_report(t, c, p);
    endtask

    // Drop valid, wait for every report, then let the pipeline settle
    task automatic wait_idle();
        @(negedge i_clk);
        smp_if.valid = 1'b0;
        while (expected_reports.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_TAIL) @(posedge i_clk);
    endtask

    // One APB transfer: setup then access, returns read data
    task automatic apb_transfer(logic wr, logic [REG_IDX_W-1:0] idx, int value,
                                output logic [APB_DATA_W-1:0] rd);
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = wr;
        paddr   = {idx, 2'b00};
        pwdata  = value;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        rd = prdata;
    endtask

    // Write a register, mirror it and read it back
    task automatic program_register(logic [REG_IDX_W-1:0] idx, int value);
        logic [APB_DATA_W-1:0] rd;
        logic [LIMIT_W-1:0]    mask;
        logic [LIMIT_W-1:0]    wval;
        mask = (idx >= REG_TEMP_BAND) ? {1'b0, {BAND_W{1'b1}}} : '1;
        wval = value[LIMIT_W-1:0] & mask;
        apb_transfer(1'b1, idx, value, rd);
        reg_shadow[idx] = wval;
        apb_transfer(1'b0, idx, 0, rd);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        check_field("register readback", wval, rd[LIMIT_W-1:0] & mask);
    endtask

    function automatic logic signed [SW-1:0] clamp(int v);
        if (v < S_MIN)
            v = S_MIN;
        if (v > S_MAX)
            v = S_MAX;
        return v[SW-1:0];
    endfunction

    // Pick a reading: calm lies inside the clear zone, otherwise edges, extremes or random
    function automatic logic signed [SW-1:0] pick_level(int lo, int hi, int bw, logic calm);
        int a;
        int b;
        int v;
        if (calm) begin
            a = lo + bw;
            b = hi - bw;
            if (a > b) begin
                a = lo;
                b = hi;
            end
            if (a > b) begin
                a = hi;
                b = lo;
            end
            a = (a < S_MIN) ? S_MIN : a;
            b = (b > S_MAX) ? S_MAX : b;
            v = a + int'($urandom_range(b - a, 0));
        end else begin
            case ($urandom_range(11, 0))
                0:       v = lo - 1;
                1:       v = lo;
                2:       v = lo + 1;
                3:       v = hi - 1;
                4:       v = hi;
                5:       v = hi + 1;
                6:       v = lo + bw - 1;
                7:       v = lo + bw;
                8:       v = hi - bw;
                9:       v = hi - bw + 1;
                10:      v = $urandom_range(1, 0) ? S_MAX : S_MIN;
                default: v = int'($signed(16'($urandom)));
            endcase
        end
        return clamp(v);
    endfunction

    // Random samples in runs of calm readings and excursions
    task automatic send_random(int count);
        logic                 en;
        logic signed [SW-1:0] t;
        logic signed [SW-1:0] c;
        logic signed [SW-1:0] p;
        repeat (count) begin
            if (calm_left == 0) begin
                calm_run  = ($urandom_range(99, 0) < 70);
                calm_left = $urandom_range(12, 1);
            end
            calm_left--;
            en = ($urandom_range(19, 0) != 0);
            t  = pick_level(S_MIN, lim(REG_TEMP_HIGH), band(REG_TEMP_BAND), calm_run);
            c  = pick_level(lim(REG_CO2_LOW), lim(REG_CO2_HIGH), band(REG_CO2_BAND), calm_run);
            p  = pick_level(lim(REG_PM_LOW), lim(REG_PM_HIGH), band(REG_PM_BAND), calm_run);
            send_sample(en, t, c, p);
        end
    endtask

    // Directed walk through every report reason, starting out of range
    task automatic test_directed_reasons();
        send_sample(1'b1, 16'sd2600, 16'sd290, 16'sd250);  // first sample already in warning
        send_sample(1'b1, 16'sd2600, 16'sd290, 16'sd250);
        send_sample(1'b1, 16'sd2100, 16'sd290, 16'sd250);  // inside limit, not past band
        send_sample(1'b1, 16'sd2600, 16'sd290, 16'sd250);  // warning periodic
        send_sample(1'b0, 16'sd0, 16'sd0, 16'sd0);         // disabled: dropped
        send_sample(1'b1, 16'sd2000, 16'sd290, 16'sd250);  // cleared at exactly band
        repeat (5) send_sample(1'b1, 16'sd2000, 16'sd290, 16'sd250);  // first, then periodic
        send_sample(1'b1, 16'sd2000, 16'sd279, 16'sd250);  // CO2 under
        send_sample(1'b1, 16'sd2000, 16'sd289, 16'sd250);
        send_sample(1'b1, 16'sd2000, 16'sd290, 16'sd250);
        send_sample(1'b1, 16'sd2000, 16'sd301, 16'sd250);  // CO2 over
        send_sample(1'b1, 16'sd2000, 16'sd291, 16'sd250);
        send_sample(1'b1, 16'sd2000, 16'sd290, 16'sd199);  // clear CO2; low PM unseen in warning
        send_sample(1'b1, 16'sd2000, 16'sd290, 16'sd250);
        send_sample(1'b1, 16'sd2000, 16'sd290, 16'sd301);  // PM over
        send_sample(1'b1, 16'sd2000, 16'sd290, 16'sd251);
        send_sample(1'b1, 16'sd2000, 16'sd290, 16'sd250);
        send_sample(1'b1, -16'sd32768, -16'sd32768, 16'sd32767);
        send_sample(1'b1, 16'sd32767, 16'sd32767, -16'sd32768);
        send_sample(1'b1, 16'sd32767, 16'sd290, 16'sd250);
        send_sample(1'b1, -16'sd32768, 16'sd290, 16'sd250);
        wait_idle();
    endtask

    // Sweep register settings, extremes included, with random traffic in each
    task automatic test_register_sweep();
        int vals [NUM_REGS];
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin
                    vals[REG_TEMP_HIGH] = S_MAX; vals[REG_CO2_LOW] = S_MAX;
                    vals[REG_CO2_HIGH]  = S_MAX; vals[REG_PM_LOW]  = S_MAX;
                    vals[REG_PM_HIGH]   = S_MAX;
                    vals[REG_TEMP_BAND] = 0; vals[REG_CO2_BAND] = 0; vals[REG_PM_BAND] = 0;
                end
                1: begin
                    vals[REG_TEMP_HIGH] = S_MIN; vals[REG_CO2_LOW] = S_MIN;
                    vals[REG_CO2_HIGH]  = S_MIN; vals[REG_PM_LOW]  = S_MIN;
                    vals[REG_PM_HIGH]   = S_MIN;
                    vals[REG_TEMP_BAND] = S_MAX; vals[REG_CO2_BAND] = S_MAX;
                    vals[REG_PM_BAND]   = S_MAX;
                end
                2: begin
                    vals[REG_TEMP_HIGH] = S_MAX; vals[REG_CO2_LOW] = S_MIN;
                    vals[REG_CO2_HIGH]  = S_MAX; vals[REG_PM_LOW]  = S_MIN;
                    vals[REG_PM_HIGH]   = S_MAX;
                    vals[REG_TEMP_BAND] = S_MAX; vals[REG_CO2_BAND] = S_MAX;
                    vals[REG_PM_BAND]   = S_MAX;
                end
                3: begin
                    vals[REG_TEMP_HIGH] = $urandom_range(4000, 0) - 2000;
                    vals[REG_CO2_LOW]   = $urandom_range(4000, 0) - 2000;
                    vals[REG_CO2_HIGH]  = vals[REG_CO2_LOW] + $urandom_range(2000, 0);
                    vals[REG_PM_LOW]    = $urandom_range(4000, 0) - 2000;
                    vals[REG_PM_HIGH]   = vals[REG_PM_LOW] + $urandom_range(2000, 0);
                    vals[REG_TEMP_BAND] = $urandom_range(300, 0);
                    vals[REG_CO2_BAND]  = $urandom_range(300, 0);
                    vals[REG_PM_BAND]   = $urandom_range(300, 0);
                end
                4: begin
                    foreach (vals[i]) vals[i] = $urandom;
                end
                default: begin
                    vals[REG_TEMP_HIGH] = RST_TEMP_HIGH; vals[REG_CO2_LOW] = RST_CO2_LOW;
                    vals[REG_CO2_HIGH]  = RST_CO2_HIGH;  vals[REG_PM_LOW]  = RST_PM_LOW;
                    vals[REG_PM_HIGH]   = RST_PM_HIGH;
                    vals[REG_TEMP_BAND] = RST_TEMP_BAND; vals[REG_CO2_BAND] = RST_CO2_BAND;
                    vals[REG_PM_BAND]   = RST_PM_BAND;
                end
            endcase
            foreach (vals[i]) program_register(i[REG_IDX_W-1:0], vals[i]);
            send_random(120);
            wait_idle();
        end
    endtask

    // Long receiver hold while the sender keeps pushing samples
    task automatic test_backpressure();
        sender_idling = 1'b0;
        repeat (2) begin
            @(posedge i_clk);
            hold_request = 1'b1;
            send_random(40);
            wait_idle();
        end
        sender_idling = 1'b1;
    endtask

    // Short bursts, each followed by a full drain
    task automatic test_drain_pauses();
        repeat (5) begin
            send_random($urandom_range(30, 5));
            wait_idle();
        end
    endtask

    // Bulk random traffic under the default limits
    task automatic test_random_traffic();
        send_random(700);
        wait_idle();
    endtask

    initial begin
        error_count        = 0;
        i_rst_n            = 1'b0;
        psel               = 1'b0;
        penable            = 1'b0;
        pwrite             = 1'b0;
        paddr              = '0;
        pwdata             = '0;
        smp_if.valid       = 1'b0;
        smp_if.enabled     = 1'b0;
        smp_if.temp_sample = '0;
        smp_if.co2_sample  = '0;
        smp_if.pm_sample   = '0;
        hold_request       = 1'b0;
        sender_idling      = 1'b1;
        burst_left         = 0;
        calm_left          = 0;
        calm_run           = 1'b1;
        warn_mode          = 1'b0;
        first_due          = 1'b1;
        tick               = '0;
        flag_state         = '0;
        reg_shadow[REG_TEMP_HIGH] = RST_TEMP_HIGH;
        reg_shadow[REG_CO2_LOW]   = RST_CO2_LOW;
        reg_shadow[REG_CO2_HIGH]  = RST_CO2_HIGH;
        reg_shadow[REG_PM_LOW]    = RST_PM_LOW;
        reg_shadow[REG_PM_HIGH]   = RST_PM_HIGH;
        reg_shadow[REG_TEMP_BAND] = RST_TEMP_BAND;
        reg_shadow[REG_CO2_BAND]  = RST_CO2_BAND;
        reg_shadow[REG_PM_BAND]   = RST_PM_BAND;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed_reasons();
        test_random_traffic();
        test_backpressure();
        test_drain_pauses();
        test_register_sweep();
        test_backpressure();

        wait_idle();
        repeat (10) @(posedge i_clk);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

>>> hysteresis_alarm_reporter.f
+incdir+sv
sv/har_pkg.sv
sv/har_ifs.sv
sv/hysteresis_alarm_reporter.sv
test/testbench.sv
